### hw/rtl/b64u_pkg.sv
// Package: types, constants and the character decode table for the base64url decoder.
package b64u_pkg;

    localparam int CountBits = 16;
    localparam int CmpBits   = (CountBits > 16) ? CountBits : 16;

    localparam logic [6:0] SYM_SPACE = 7'h40;
    localparam logic [6:0] SYM_TERM  = 7'h41;
    localparam logic [6:0] SYM_BAD   = 7'h42;

    localparam logic [15:0] LIMIT_RESET = 16'hffff;

    typedef enum logic [1:0] {
        CAUSE_RUN   = 2'd0,
        CAUSE_TERM  = 2'd1,
        CAUSE_BAD   = 2'd2,
        CAUSE_LIMIT = 2'd3
    } cause_t;

    typedef struct packed {
        logic [7:0] character;
        logic       message_start;
    } sym_item_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  data_byte;
        logic        stopped;
        logic [1:0]  stop_cause;
        logic [15:0] byte_count;
    } res_item_t;

    function automatic logic [6:0] classify(input logic [7:0] c);
        logic [6:0] r;
        r = SYM_BAD;
        if (c >= 8'h41 && c <= 8'h5a) r = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7a) r = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) r = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2d) r = 7'd62;
        else if (c == 8'h5f) r = 7'd63;
        else if ((c >= 8'h09 && c <= 8'h0d) || c == 8'h20) r = SYM_SPACE;
        else if (c == 8'h00 || c == 8'h3d) r = SYM_TERM;
        return r;
    endfunction

endpackage

### hw/rtl/b64u_in_stage.sv
// Input register stage: captures one character transaction and hands it to the decode stage.
module b64u_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sym_valid,
    output logic                sym_ready,
    input  b64u_pkg::sym_item_t sym_item,
    output logic                q_valid,
    input  logic                q_ready,
    output b64u_pkg::sym_item_t q_item
);
    import b64u_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    sym_item_t item_reg;

    assign sym_ready  = !valid_reg || q_ready;
    assign valid_next = sym_ready ? sym_valid : valid_reg;
    assign q_valid    = valid_reg;
    assign q_item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sym_ready && sym_valid)
        begin
            item_reg <= sym_item;
        end
    end

endmodule

### hw/rtl/b64u_decode.sv
// Decode stage: message state, 6-to-8 bit packing, stop logic and the result register.
module b64u_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  b64u_pkg::sym_item_t q_item,
    input  logic [15:0]         byte_limit,
    output logic                res_valid,
    input  logic                res_ready,
    output b64u_pkg::res_item_t res_item
);
    import b64u_pkg::*;

    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

    logic [11:0]          acc_reg, acc_next;
    logic [3:0]           held_reg, held_next;
    logic [CountBits-1:0] cnt_reg, cnt_next;
    logic                 halt_reg, halt_next;
    cause_t               cause_reg, cause_next;
    logic                 res_valid_reg, res_valid_next;
    res_item_t            res_item_reg, res_item_next;

    logic       take;
    logic [6:0] sym;
    logic [11:0] acc_sh;
    logic [3:0]  held_sum;
    logic        emit;
    logic [7:0]  data;

    assign q_ready   = !res_valid_reg || res_ready;
    assign take      = q_valid && q_ready;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    always_comb
    begin
        acc_next   = acc_reg;
        held_next  = held_reg;
        cnt_next   = cnt_reg;
        halt_next  = halt_reg;
        cause_next = cause_reg;
        emit       = 1'b0;
        data       = 8'h00;
        sym        = classify(q_item.character);
        acc_sh     = 12'h000;
        held_sum   = 4'd0;

        if (q_item.message_start)
        begin
            acc_next   = 12'h000;
            held_next  = 4'd0;
            cnt_next   = '0;
            halt_next  = 1'b0;
            cause_next = CAUSE_RUN;
        end

        if (!halt_next)
        begin
            if (CmpBits'(cnt_next) >= CmpBits'(byte_limit))
            begin
                halt_next  = 1'b1;
                cause_next = CAUSE_LIMIT;
            end
            else if (sym == SYM_TERM)
            begin
                halt_next  = 1'b1;
                cause_next = CAUSE_TERM;
            end
            else if (sym == SYM_BAD)
            begin
                halt_next  = 1'b1;
                cause_next = CAUSE_BAD;
            end
            else if (sym != SYM_SPACE)
            begin
                acc_sh   = {acc_next[5:0], sym[5:0]};
                held_sum = held_next + 4'd6;
                acc_next  = acc_sh;
                held_next = held_sum;
                if (held_sum >= 4'd8)
                begin
                    emit      = 1'b1;
                    held_next = held_sum - 4'd8;
                    case (held_next)
                        4'd0:    begin data = acc_sh[7:0];  acc_next = 12'h000; end
                        4'd2:    begin data = acc_sh[9:2];  acc_next = {10'h000, acc_sh[1:0]}; end
                        4'd4:    begin data = acc_sh[11:4]; acc_next = {8'h00, acc_sh[3:0]}; end
                        default: begin data = acc_sh[11:4]; acc_next = {8'h00, acc_sh[3:0]}; end
                    endcase
                    if (cnt_next != CountMax)
                    begin
                        cnt_next = cnt_next + 1'b1;
                    end
                    if (CmpBits'(cnt_next) >= CmpBits'(byte_limit))
                    begin
                        halt_next  = 1'b1;
                        cause_next = CAUSE_LIMIT;
                    end
                end
            end
        end

        res_item_next.byte_valid = emit;
        res_item_next.data_byte  = data;
        res_item_next.stopped    = halt_next;
        res_item_next.stop_cause = cause_next;
        res_item_next.byte_count = 16'(cnt_next);

        res_valid_next = take ? 1'b1 : (res_valid_reg && !res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 12'h000;
            held_reg      <= 4'd0;
            cnt_reg       <= '0;
            halt_reg      <= 1'b0;
            cause_reg     <= CAUSE_RUN;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                acc_reg   <= acc_next;
                held_reg  <= held_next;
                cnt_reg   <= cnt_next;
                halt_reg  <= halt_next;
                cause_reg <= cause_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_item_reg <= res_item_next;
        end
    end

endmodule

### hw/rtl/base64url_decoder.sv
// Top level of the streaming base64url decoder.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  sym     | in        | sym_valid/sym_ready   | sym_item (character, start)
//  res     | out       | res_valid/res_ready   | res_item (one per character)
//  cfg     | in        | cfg_valid/cfg_ready   | cfg_data (byte_limit)
//
// One character transaction per cycle sustained while res_ready stays high; each accepted
// character passes the input register, then is decoded into the result register.
// Reset clears message state and sets byte_limit to 65535.
// A stalled res channel holds the result; one more character waits in the
// input register before sym_ready drops. cfg_ready is always high.
module base64url_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sym_valid,
    output logic                sym_ready,
    input  b64u_pkg::sym_item_t sym_item,
    output logic                res_valid,
    input  logic                res_ready,
    output b64u_pkg::res_item_t res_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import b64u_pkg::*;

    logic        q_valid;
    logic        q_ready;
    sym_item_t   q_item;
    logic [15:0] limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    b64u_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym_item  (sym_item),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    b64u_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .byte_limit (limit_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

endmodule

### hw/rtl/b64u_checker.sv
// Port-level checker for the base64url decoder, bound to the top level.
module b64u_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input b64u_pkg::res_item_t res_item
);
    import b64u_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result changed or dropped while stalled");

    a_stop_cause: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.stopped == (res_item.stop_cause != CAUSE_RUN)))
        else $error("stopped flag and stop cause disagree");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.byte_valid |-> res_item.data_byte == 8'h00)
        else $error("data byte nonzero without a decoded byte");

    a_no_byte_stopped_cause: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.byte_valid && res_item.stopped
            |-> res_item.stop_cause == CAUSE_LIMIT)
        else $error("byte emitted on a step that stopped for a reason other than limit");

endmodule

bind base64url_decoder b64u_checker u_b64u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
);

### bench/base64url_decode_checker.sv
// Checker for the base64url decoder: predicts each result and compares it with what the block returns.
module base64url_decode_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sym_valid,
    input  logic                sym_ready,
    input  b64u_pkg::sym_item_t sym_item,
    input  logic                res_valid,
    input  logic                res_ready,
    input  b64u_pkg::res_item_t res_item,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    output int                  mismatch_count,
    output int                  pending_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import b64u_pkg::*;

    logic [15:0] limit_reg;
    logic [11:0] acc_bits;
    logic [3:0]  acc_count;
    logic [15:0] bytes_out;
    logic        halted;
    cause_t      halt_cause;
    int          err_total;
    res_item_t   decoded_q[$];

    function automatic logic [6:0] symbol_value(input logic [7:0] c);
        if (c inside {[8'h41:8'h5a]})
            return 7'(c - 8'h41);
        if (c inside {[8'h61:8'h7a]})
            return 7'(c - 8'h47);
        if (c inside {[8'h30:8'h39]})
            return 7'(c + 8'h04);
        if (c == 8'h2d)
            return 7'd62;
        if (c == 8'h5f)
            return 7'd63;
        if (c inside {[8'h09:8'h0d], 8'h20})
            return SYM_SPACE;
        if (c inside {8'h00, 8'h3d})
            return SYM_TERM;
        return SYM_BAD;
    endfunction

    function automatic void clear_message();
        acc_bits   = '0;
        acc_count  = '0;
        bytes_out  = '0;
        halted     = 1'b0;
        halt_cause = CAUSE_RUN;
    endfunction

    function automatic res_item_t decode_char(input sym_item_t it);
        res_item_t   r;
        logic [6:0]  code;
        logic [11:0] merged;
        logic [3:0]  total;
        r = '0;
        if (it.message_start)
            clear_message();
        if (!halted)
        begin
            if (bytes_out >= limit_reg)
            begin
                halted     = 1'b1;
                halt_cause = CAUSE_LIMIT;
            end
            else
            begin
                code = symbol_value(it.character);
                if (code == SYM_TERM)
                begin
                    halted     = 1'b1;
                    halt_cause = CAUSE_TERM;
                end
                else if (code == SYM_BAD)
                begin
                    halted     = 1'b1;
                    halt_cause = CAUSE_BAD;
                end
                else if (code < 7'd64)
                begin
                    merged = {acc_bits[5:0], code[5:0]};
                    total  = acc_count + 4'd6;
                    if (total >= 4'd8)
                    begin
                        total       = total - 4'd8;
                        r.byte_valid = 1'b1;
                        r.data_byte  = 8'(merged >> total);
                        merged       = merged & ((12'd1 << total) - 12'd1);
                        if (bytes_out != 16'hffff)
                            bytes_out = bytes_out + 16'd1;
                        if (bytes_out >= limit_reg)
                        begin
                            halted     = 1'b1;
                            halt_cause = CAUSE_LIMIT;
                        end
                    end
                    acc_bits  = merged;
                    acc_count = total;
                end
            end
        end
        r.stopped    = halted;
        r.stop_cause = halt_cause;
        r.byte_count = bytes_out;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            clear_message();
            limit_reg = LIMIT_RESET;
            decoded_q.delete();
            err_total = 0;
            mismatch_count  <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("result transaction with no character pending");
                    err_total++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("byte_valid", want.byte_valid, res_item.byte_valid);
                    check_field("data_byte", want.data_byte, res_item.data_byte);
                    check_field("stopped", want.stopped, res_item.stopped);
                    check_field("stop_cause", want.stop_cause, res_item.stop_cause);
                    check_field("byte_count", want.byte_count, res_item.byte_count);
                end
            end
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;
            if (sym_valid && sym_ready)
                decoded_q.push_back(decode_char(sym_item));
            mismatch_count  <= err_total;
            pending_results <= decoded_q.size();
        end
    end

endmodule

### bench/base64url_decoder_test.sv
// Testbench top for the base64url decoder: clock, reset, stimulus and verdict.
module base64url_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import b64u_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        sym_valid  = 1'b0;
    logic        sym_ready;
    sym_item_t   sym_item   = '0;
    logic        res_valid;
    logic        res_ready  = 1'b0;
    res_item_t   res_item;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data   = '0;
    int          mismatch_count;
    int          pending_results;
    int          idle_pct   = 0;
    int          stall_pct  = 0;
    int          chars_sent = 0;
    int          quiet_cycles = 0;

    base64url_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym_item  (sym_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    base64url_decode_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .sym_valid       (sym_valid),
        .sym_ready       (sym_ready),
        .sym_item        (sym_item),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res_item        (res_item),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (stall_pct == 0)
            res_ready <= 1'b1;
        else
            res_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sym_valid && sym_ready) || (res_valid && res_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [7:0] b64_char(input int unsigned idx);
        if (idx < 26)
            return 8'(8'h41 + idx);
        if (idx < 52)
            return 8'(8'h61 + idx - 26);
        if (idx < 62)
            return 8'(8'h30 + idx - 52);
        return (idx == 62) ? 8'h2d : 8'h5f;
    endfunction

    function automatic logic [7:0] space_char();
        int unsigned k;
        k = $urandom_range(5);
        return (k == 5) ? 8'h20 : 8'(8'h09 + k);
    endfunction

    function automatic logic [7:0] bad_char();
        case ($urandom_range(7))
            0: return 8'h2b;
            1: return 8'h2f;
            2: return 8'h2e;
            3: return 8'h21;
            4: return 8'h80;
            5: return 8'hff;
            6: return 8'h7e;
            default: return 8'h40;
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(6))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd2;
            3: return 16'($urandom_range(3, 40));
            4: return 16'hffff;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic st);
        sym_item_t it;
        it.character     = ch;
        it.message_start = st;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            sym_valid <= 1'b0;
            @(posedge clk);
        end
        sym_valid <= 1'b1;
        sym_item  <= it;
        do
            @(posedge clk);
        while (!sym_ready);
        chars_sent++;
    endtask

    task automatic drain();
        sym_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [15:0] value);
        drain();
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_message();
        int          body;
        int unsigned pick;
        logic [7:0]  ch;
        logic        st;
        body = $urandom_range(24);
        send_char(b64_char($urandom_range(63)), 1'b1);
        repeat (body)
        begin
            pick = $urandom_range(99);
            st   = ($urandom_range(49) == 0);
            if (pick < 85)
                ch = b64_char($urandom_range(63));
            else if (pick < 93)
                ch = space_char();
            else
                ch = 8'($urandom_range(255));
            send_char(ch, st);
        end
        pick = $urandom_range(9);
        if (pick < 5)
            send_char(pick[0] ? 8'h3d : 8'h00, 1'b0);
        else if (pick < 7)
            send_char(bad_char(), 1'b0);
        repeat ($urandom_range(2))
            send_char(8'($urandom_range(255)), 1'b0);
    endtask

    initial
    begin
        int target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // "TWFu" decodes to "Man"
        send_char("T", 1'b1);
        send_char("W", 1'b0);
        send_char("F", 1'b0);
        send_char("u", 1'b0);
        send_char(8'h20, 1'b0);
        send_char(8'h09, 1'b0);
        send_char(8'h0d, 1'b0);
        send_char("-", 1'b0);
        send_char("_", 1'b0);
        send_char("9", 1'b0);
        send_char("a", 1'b0);
        send_char("Z", 1'b0);
        send_char("+", 1'b0);
        send_char("A", 1'b0);
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b1);
        send_char("=", 1'b1);
        send_char("/", 1'b1);

        set_limit(16'd0);
        send_char("A", 1'b1);
        set_limit(16'd1);
        send_char("Q", 1'b1);
        send_char("Q", 1'b0);
        send_char("z", 1'b0);

        // limit lowered below the count of an open message
        set_limit(16'hffff);
        send_char("z", 1'b1);
        send_char("z", 1'b0);
        send_char("z", 1'b0);
        send_char("z", 1'b0);
        set_limit(16'd2);
        send_char("=", 1'b0);

        // one longer message under the full limit
        set_limit(16'hffff);
        send_char(b64_char($urandom_range(63)), 1'b1);
        repeat (63)
            send_char(b64_char($urandom_range(63)), 1'b0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            set_limit(pick_limit());
            target = chars_sent + 420;
            while (chars_sent < target)
            begin
                if ($urandom_range(9) == 0)
                    set_limit(pick_limit());
                send_message();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
